@@ rtl/stack_vm_integer_alu_unit_assert.svh @@
// Assertion macros for the stack VM integer ALU
`ifndef STACK_VM_INTEGER_ALU_UNIT_ASSERT_SVH
`define STACK_VM_INTEGER_ALU_UNIT_ASSERT_SVH
// Assert an implication on every clock edge outside reset
`define SVA_IMPLY(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);
// Assert an implication that must hold in the next cycle
`define SVA_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);
`endif

@@ rtl/svia_pkg.sv @@
// ------------------------------------------------------------------------
// svia_pkg
// Types and opcode codes shared by the stack VM integer ALU.
// ------------------------------------------------------------------------
package svia_pkg;
    localparam int WORD_W = 32;
    localparam int OP_W   = 5;

    localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 5'd3;
    localparam logic [OP_W-1:0] OP_MOD  = 5'd4;
    localparam logic [OP_W-1:0] OP_AND  = 5'd5;
    localparam logic [OP_W-1:0] OP_OR   = 5'd6;
    localparam logic [OP_W-1:0] OP_XOR  = 5'd7;
    localparam logic [OP_W-1:0] OP_BNOT = 5'd8;
    localparam logic [OP_W-1:0] OP_SHL  = 5'd9;
    localparam logic [OP_W-1:0] OP_SHR  = 5'd10;
    localparam logic [OP_W-1:0] OP_GT   = 5'd11;
    localparam logic [OP_W-1:0] OP_LT   = 5'd12;
    localparam logic [OP_W-1:0] OP_GE   = 5'd13;
    localparam logic [OP_W-1:0] OP_LE   = 5'd14;
    localparam logic [OP_W-1:0] OP_EQ   = 5'd15;
    localparam logic [OP_W-1:0] OP_NE   = 5'd16;
    localparam logic [OP_W-1:0] OP_LNOT = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [WORD_W-1:0] operand_top;
        logic signed [WORD_W-1:0] operand_next;
    } svia_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_word;
        logic [1:0]               words_consumed;
    } svia_out_t;
endpackage

@@ rtl/svia_div_cell.sv @@
// ------------------------------------------------------------------------
// svia_div_cell
// One restoring-division step on magnitudes; passes its item to the next cell.
// ------------------------------------------------------------------------
module svia_div_cell #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         valid_in,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] quo_in,
    input  logic [W-1:0] div_in,
    input  logic [W+6:0] side_in,
    output logic         valid_out,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] quo_out,
    output logic [W-1:0] div_out,
    output logic [W+6:0] side_out
);
    logic [W:0] trial;
    logic [W:0] diff;

    // shift in next dividend bit and try subtracting
    assign trial = {rem_in, quo_in[W-1]};
    assign diff  = trial - {1'b0, div_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out <= 1'b0;
        end else if (en) begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!diff[W]) begin
                rem_out <= diff[W-1:0];
                quo_out <= {quo_in[W-2:0], 1'b1};
            end else begin
                rem_out <= trial[W-1:0];
                quo_out <= {quo_in[W-2:0], 1'b0};
            end
            div_out  <= div_in;
            side_out <= side_in;
        end
    end
endmodule

@@ rtl/stack_vm_integer_alu_unit.sv @@
// ------------------------------------------------------------------------
// stack_vm_integer_alu_unit
// Integer ALU of a stack VM: a front cell, a chain of divide cells, a
// finishing cell and an output register.
// ------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one operation (opcode, top, next word).
//   m_valid/m_ready/m_data carry the result word and words consumed.
//   Every operation walks the same pipeline: one front cell, WORD_W
//   divide cells (one quotient bit each), one finish cell and the
//   output register, in that order.
//   Throughput is one transaction per cycle unless the receiver stalls; the
//   divide chain sets the latency, the 32x32 front-cell multiplier the clock.
//   The whole chain advances only while the output register is empty or
//   being drained; a stalled receiver freezes every cell, and s_ready
//   drops with it. Results leave in acceptance order.
//   Reset (aresetn low, synchronous) clears every valid bit and holds
//   s_ready low; the pipe is empty and ready as soon as reset is released.
//   Opcodes outside 0..17 give result 0 and words consumed 0.
// ------------------------------------------------------------------------
module stack_vm_integer_alu_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  svia_pkg::svia_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output svia_pkg::svia_out_t  m_data
);
    import svia_pkg::*;
    `include "stack_vm_integer_alu_unit_assert.svh"

    localparam int W = WORD_W;
    localparam int SW = W + 7;    // side band: op(5), sign q, sign r, plain result
    localparam int SHW = $clog2(W);

    logic en;
    logic out_valid_reg;
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en && aresetn;

    // front cell: operands local to the word width
    logic signed [W-1:0] a, b;
    logic [OP_W-1:0]     op;
    assign a  = W'(s_data.operand_top);
    assign b  = W'(s_data.operand_next);
    assign op = s_data.opcode;

    logic [W-1:0] plain;
    logic [W-1:0] prod;
    logic         sh_ok;
    assign prod  = W'(a * b);
    assign sh_ok = !b[W-1] && (b < W);

    // compute everything except div and mod
    always_comb begin
        plain = '0;
        case (op)
            OP_ADD:  plain = a + b;
            OP_SUB:  plain = a - b;
            OP_MUL:  plain = prod;
            OP_AND:  plain = a & b;
            OP_OR:   plain = a | b;
            OP_XOR:  plain = a ^ b;
            OP_BNOT: plain = ~a;
            OP_SHL:  plain = sh_ok ? (a << b[SHW-1:0]) : '0;
            OP_SHR:  plain = sh_ok ? W'(a >>> b[SHW-1:0]) : {W{a[W-1]}};
            OP_GT:   plain = W'(a > b);
            OP_LT:   plain = W'(a < b);
            OP_GE:   plain = W'(a >= b);
            OP_LE:   plain = W'(a <= b);
            OP_EQ:   plain = W'(a == b);
            OP_NE:   plain = W'(a != b);
            OP_LNOT: plain = W'(a == '0);
            default: plain = '0;
        endcase
    end

    logic [W-1:0] mag_a, mag_b;
    assign mag_a = a[W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[W-1] ? (~b + 1'b1) : b;

    logic [W:0]    c_valid;
    logic [W-1:0]  c_rem [W+1];
    logic [W-1:0]  c_quo [W+1];
    logic [W-1:0]  c_div [W+1];
    logic [SW-1:0] c_side [W+1];

    // register front cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid[0] <= 1'b0;
        end else if (en) begin
            c_valid[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_rem[0]  <= '0;
            c_quo[0]  <= mag_a;
            c_div[0]  <= mag_b;
            c_side[0] <= {op, a[W-1] ^ b[W-1], a[W-1], plain};
        end
    end

    // chain of divide cells
    for (genvar i = 0; i < W; i++) begin : g_cell
        svia_div_cell #(.W(W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (c_valid[i]),
            .rem_in    (c_rem[i]),
            .quo_in    (c_quo[i]),
            .div_in    (c_div[i]),
            .side_in   (c_side[i]),
            .valid_out (c_valid[i+1]),
            .rem_out   (c_rem[i+1]),
            .quo_out   (c_quo[i+1]),
            .div_out   (c_div[i+1]),
            .side_out  (c_side[i+1])
        );
    end

    // finish cell: sign fix, zero divisor, opcode select
    logic [OP_W-1:0] f_op;
    logic [W-1:0]    f_plain, f_q, f_r;
    logic [W-1:0]    f_word;
    logic [1:0]      f_used;
    logic            f_zero;
    assign f_op    = c_side[W][SW-1 -: OP_W];
    assign f_plain = c_side[W][W-1:0];
    assign f_zero  = (c_div[W] == '0);
    assign f_q     = c_side[W][W+1] ? (~c_quo[W] + 1'b1) : c_quo[W];
    assign f_r     = c_side[W][W]   ? (~c_rem[W] + 1'b1) : c_rem[W];

    always_comb begin
        f_word = f_plain;
        f_used = 2'd2;
        case (f_op)
            OP_DIV:  f_word = f_zero ? '0 : f_q;
            OP_MOD:  f_word = f_zero ? '0 : f_r;
            OP_BNOT, OP_LNOT: f_used = 2'd1;
            default: begin
                if (f_op > OP_LNOT) begin
                    f_used = 2'd0;
                end
            end
        endcase
    end

    // output register
    logic signed [W-1:0] out_word_reg;
    logic [1:0]          out_used_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= c_valid[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_word_reg <= f_word;
            out_used_reg <= f_used;
        end
    end

    assign m_valid = out_valid_reg;
    always_comb begin
        m_data = '0;
        m_data.result_word    = WORD_W'(out_word_reg);
        m_data.words_consumed = out_used_reg;
    end

    `SVA_IMPLY(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_ready,
        "ready low with empty output register")
    `SVA_NEXT(a_hold_stall, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result changed while stalled")
    `SVA_NEXT(a_chain_frozen, aclk, aresetn, !en, $stable(c_valid),
        "divide chain moved while stalled")
    `SVA_IMPLY(a_used_range, aclk, aresetn, m_valid,
        m_data.words_consumed != 2'd3, "bad words consumed")
endmodule
